// ===== src/calibrated_moving_average_macros.svh =====
// assertion macros for the calibrated moving average block
// expects clk and rst_n in the scope of the module that uses them
`ifndef CALIBRATED_MOVING_AVERAGE_MACROS_SVH
`define CALIBRATED_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication
`define CMA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cma assertion failed");

// next-cycle implication
`define CMA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cma assertion failed");

`endif

// ===== src/cma_pkg.sv =====
// shared types and constants for the calibrated moving average block
// no dependencies
package cma_pkg;

  localparam int SMP_W          = 16;
  localparam int PCT_SCALE      = 100;
  localparam int DEF_WINDOW_LEN = 8;
  localparam int DIVD_W         = 32;
  localparam int DVS_W          = 7;
  localparam int CAL_STEPS      = DIVD_W / 2;
  localparam int STP_W          = $clog2(CAL_STEPS + 1);
  localparam int REG_IDX_W      = 1;

  localparam logic [REG_IDX_W-1:0] REG_GAIN   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET = 1'b1;

  localparam logic signed [SMP_W-1:0] GAIN_RESET = SMP_W'(PCT_SCALE);

  typedef struct packed {
    logic capture;
    logic mul;
    logic ld_cal;
    logic cal;
    logic upd;
    logic ld_mean;
    logic out_load;
  } cma_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } cma_sts_t;

endpackage

// ===== src/cma_div.sv =====
// iterative unsigned divider, two quotient bits per cycle
// depends on cma_pkg
`include "calibrated_moving_average_macros.svh"

module cma_div
  import cma_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]  divisor,
  input  logic [STP_W-1:0]  steps,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic [STP_W-1:0]  cnt_r, cnt_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W-1:0]  rem_v;
  logic [DIVD_W-1:0] q_v;
  logic [DVS_W:0]    sh_v;
  logic              qbit_v;

  always_comb begin
    rem_v = rem_r;
    q_v   = q_r;
    sh_v  = '0;
    qbit_v = 1'b0;
    for (int i = 0; i < 2; i++) begin
      sh_v = {rem_v, q_v[DIVD_W-1]};
      if (sh_v >= {1'b0, dvs_r}) begin
        sh_v   = sh_v - {1'b0, dvs_r};
        qbit_v = 1'b1;
      end else begin
        qbit_v = 1'b0;
      end
      rem_v = sh_v[DVS_W-1:0];
      q_v   = {q_v[DIVD_W-2:0], qbit_v};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = rem_v;
      q_nxt   = q_v;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STP_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

  `CMA_ASSERT_NXT(a_div_start_busy, start, busy_r)
  `CMA_ASSERT_NXT(a_div_last_step, busy_r && !start && cnt_r == STP_W'(1), !busy_r)

endmodule

// ===== src/cma_dp.sv =====
// datapath: calibration, sample ring, running total, output register
// depends on cma_pkg and cma_div
`include "calibrated_moving_average_macros.svh"

module cma_dp
  import cma_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cma_cmd_t                cmd,
  output cma_sts_t                sts,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [SMP_W-1:0]        cfg_wdata,
  input  logic signed [SMP_W-1:0] in_raw_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_calibrated_value,
  output logic signed [SMP_W-1:0] out_window_mean
);

  localparam int IDX_W       = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int TOTAL_W     = SMP_W + $clog2(WINDOW_LEN);
  localparam int MEAN_STEPS  = (TOTAL_W + 1) / 2;
  localparam int MEAN_SHIFT  = DIVD_W - 2 * MEAN_STEPS;
  localparam int SUM_W       = DIVD_W + 2;

  logic signed [SMP_W-1:0]   gain_r, offset_r;
  logic signed [SMP_W-1:0]   sample_r;
  logic signed [SMP_W-1:0]   old_r;
  logic signed [DIVD_W-1:0]  prod_r;
  logic signed [SMP_W-1:0]   cal_r;
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0]          pos_r;
  logic                      full_r;
  logic                      neg_r;
  logic                      out_valid_r;
  logic signed [SMP_W-1:0]   out_cal_r, out_mean_r;
  logic signed [SMP_W-1:0]   ring [WINDOW_LEN];

  logic                      div_start;
  logic [DIVD_W-1:0]         div_dividend;
  logic [DVS_W-1:0]          div_divisor;
  logic [STP_W-1:0]          div_steps;
  logic                      div_busy;
  logic [DIVD_W-1:0]         div_quot;

  logic [DIVD_W-1:0]         prod_mag;
  logic [TOTAL_W-1:0]        total_mag;
  logic signed [SUM_W-1:0]   scaled, cal_sum;
  logic signed [SMP_W-1:0]   cal_sat;
  logic signed [SMP_W-1:0]   old_val;
  logic signed [TOTAL_W:0]   mean_mag, mean_val;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN: begin
          if (cfg_wdata != '0) begin
            gain_r <= cfg_wdata;
          end
        end
        REG_OFFSET: offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sample ring, registered read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      old_r <= ring[pos_r];
    end
    if (cmd.upd) begin
      ring[pos_r] <= cal_r;
    end
  end

  assign prod_mag  = prod_r[DIVD_W-1] ? DIVD_W'(-prod_r) : DIVD_W'(prod_r);
  assign total_mag = total_r[TOTAL_W-1] ? TOTAL_W'(-total_r) : TOTAL_W'(total_r);

  always_comb begin
    div_start    = cmd.ld_cal | cmd.ld_mean;
    div_dividend = prod_mag;
    div_divisor  = DVS_W'(PCT_SCALE);
    div_steps    = STP_W'(CAL_STEPS);
    if (cmd.ld_mean) begin
      div_dividend = DIVD_W'(total_mag) << MEAN_SHIFT;
      div_divisor  = full_r ? DVS_W'(WINDOW_LEN) : DVS_W'(pos_r);
      div_steps    = STP_W'(MEAN_STEPS);
    end
  end

  cma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // scale sign, offset and saturation
  always_comb begin
    scaled = neg_r ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
    cal_sum = scaled + SUM_W'(offset_r);
    if (cal_sum > SUM_W'(32767)) begin
      cal_sat = 16'sh7fff;
    end else if (cal_sum < -SUM_W'(32768)) begin
      cal_sat = -16'sh8000;
    end else begin
      cal_sat = cal_sum[SMP_W-1:0];
    end
  end

  assign old_val   = full_r ? old_r : '0;
  assign total_nxt = total_r - TOTAL_W'(old_val) + TOTAL_W'(cal_r);
  assign mean_mag  = $signed({1'b0, div_quot[TOTAL_W-1:0]});
  assign mean_val  = neg_r ? -mean_mag : mean_mag;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_raw_sample;
    end
    if (cmd.mul) begin
      prod_r <= DIVD_W'(sample_r * gain_r);
    end
    if (cmd.ld_cal) begin
      neg_r <= prod_r[DIVD_W-1];
    end else if (cmd.ld_mean) begin
      neg_r <= total_r[TOTAL_W-1];
    end
    if (cmd.cal) begin
      cal_r <= cal_sat;
    end
    if (cmd.out_load) begin
      out_cal_r  <= cal_r;
      out_mean_r <= mean_val[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      pos_r       <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd) begin
        total_r <= total_nxt;
        if (pos_r == IDX_W'(WINDOW_LEN - 1)) begin
          pos_r  <= '0;
          full_r <= 1'b1;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_busy          = div_busy;
  assign sts.out_free          = !out_valid_r || out_ready;
  assign out_valid             = out_valid_r;
  assign out_calibrated_value  = out_cal_r;
  assign out_window_mean       = out_mean_r;

  `CMA_ASSERT_IMP(a_gain_nonzero, 1'b1, gain_r != '0)

endmodule

// ===== src/cma_ctrl.sv =====
// controller state machine sequencing one sample through the datapath
// depends on cma_pkg
`include "calibrated_moving_average_macros.svh"

module cma_ctrl
  import cma_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output cma_cmd_t cmd,
  input  cma_sts_t sts
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_LD1  = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_CAL  = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_LD2  = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LD1;
      end
      S_LD1: begin
        cmd.ld_cal = 1'b1;
        state_nxt  = S_DIV1;
      end
      S_DIV1: begin
        if (!sts.div_busy) begin
          state_nxt = S_CAL;
        end
      end
      S_CAL: begin
        cmd.cal   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_LD2;
      end
      S_LD2: begin
        cmd.ld_mean = 1'b1;
        state_nxt   = S_DIV2;
      end
      S_DIV2: begin
        if (!sts.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CMA_ASSERT_NXT(a_accept_to_mul, in_valid && in_ready, state_r == S_MUL)
  `CMA_ASSERT_IMP(a_out_load_free, cmd.out_load, sts.out_free)

endmodule

// ===== src/calibrated_moving_average.sv =====
// calibrated moving average: one result per sample; the time from transfer in to result
// valid is mostly set by the shared two-bit-per-cycle divider, run once for the /100
// scaling and once for the mean; a new sample is accepted only after the previous result
// is loaded into the output register, a new sample taken while a result waits
// synchronous active-low reset: gain 100, offset 0, ring counted as empty, no result
// top level, depends on cma_pkg, cma_ctrl and cma_dp
module calibrated_moving_average
  import cma_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [SMP_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] in_raw_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_calibrated_value,
  output logic signed [SMP_W-1:0] out_window_mean
);

  cma_cmd_t cmd;
  cma_sts_t sts;

  cma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  cma_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_raw_sample        (in_raw_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_calibrated_value (out_calibrated_value),
    .out_window_mean      (out_window_mean)
  );

endmodule
